[rtl/core/vfpt_pkg.sv]
package vfpt_pkg;

    localparam int TIME_BITS        = 60;
    localparam int NP_BITS          = TIME_BITS + 1;
    localparam int IDX_BITS         = 55;
    localparam int TICKS_PER_SECOND = 10000000;
    localparam int RATE_W           = 16;
    localparam int SCALE_W          = 10;
    localparam int D_W              = 3;
    localparam int TD_W             = 34;
    localparam int DT_W             = 37;
    localparam int STEP_W           = 36;
    localparam int DVD_W            = TIME_BITS + 2;
    localparam int DVS_W            = DT_W;
    localparam int CNT_W            = 6;
    localparam int NUM_W            = 35;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    // Division by three is a multiply by the rounded-up reciprocal 2^40/3, exact
    // for every dividend below 2^39, done as two half-width partial products.
    localparam int DIV3_W           = DT_W + 1;
    localparam int HALF3_W          = DIV3_W / 2;
    localparam int RECIP3_W         = 39;
    localparam int RECIP3_SH        = 40;
    localparam int PROD3_W          = HALF3_W + RECIP3_W;
    localparam int SUM3_W           = DIV3_W + RECIP3_W;
    localparam logic [RECIP3_W-1:0] RECIP3 = 39'd366503875926;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = 1'd1;

    localparam logic [NUM_W-1:0] TICKS_X3     = NUM_W'(TICKS_PER_SECOND * 3);
    localparam logic [D_W-1:0]   DEFAULT_D    = 3'd4;
    localparam logic [RATE_W-1:0] RATE_ONE    = 16'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FORM,
        ST_DT,
        ST_STEP,
        ST_STEPH,
        ST_BASE,
        ST_ALIGN,
        ST_ALIGNH,
        ST_SKIP,
        ST_IDX,
        ST_IDXW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic            hit;
        logic [D_W-1:0]  d;
        logic [TD_W-1:0] td;
    } rate_entry_t;

    function automatic rate_entry_t rate_lookup(input logic [RATE_W-1:0] rate);
        rate_entry_t e;
        e.hit = 1'b1;
        e.d   = DEFAULT_D;
        e.td  = '0;
        case (rate)
            16'd24:
            begin
                e.d  = 3'd5;
                e.td = 34'd125000;
            end
            16'd2398, 16'd24000:
            begin
                e.d  = 3'd5;
                e.td = 34'd125125;
            end
            16'd25, 16'd50:
            begin
                e.td = 34'd150000;
            end
            16'd30, 16'd60:
            begin
                e.td = 34'd125000;
            end
            16'd2997, 16'd30000, 16'd60000:
            begin
                e.td = 34'd125125;
            end
            default:
            begin
                e.hit = 1'b0;
            end
        endcase
        return e;
    endfunction

endpackage

[rtl/core/vfpt_div.sv]
module vfpt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vfpt_pkg::div_req_t req,
    output vfpt_pkg::div_rsp_t rsp
);
    import vfpt_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[rtl/core/video_frame_pulse_timer.sv]
// Frame pulse timer driven by reference clock readings in 100 ns units.
// Input channel: in_valid, in_stall and now_time; one request is a clock reading.
// Output channel: out_valid, out_stall and the five result fields; every input
// request gives exactly one output request.
// Configuration: cfg_wr_en, cfg_index and cfg_data write frame_rate (index 0) or
// rate_scale (index 1); any write restarts frame alignment on the next request.
// One request is worked at a time: in_stall is high from acceptance until the
// result has been taken. All divisions run on one shared restoring divider of
// 62 steps; division by three uses a multiply done as two partial products.
// The first request after reset or a write needs at most two divisions, and
// so does each later request. A new request can be taken in the cycle after
// the result has been taken. Reset clears the time, the schedule and the start
// flag, and loads frame rate 25 and scale 1. While out_stall is high the result
// is held unchanged and no new request is taken.
module video_frame_pulse_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [vfpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfpt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [vfpt_pkg::TIME_BITS-1:0]      now_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [vfpt_pkg::TIME_BITS-1:0]      reported_time,
    output logic                                time_advanced,
    output logic                                frame_pulse,
    output logic [vfpt_pkg::NP_BITS-1:0]        next_pulse_time,
    output logic [vfpt_pkg::IDX_BITS-1:0]       frame_index
);
    import vfpt_pkg::*;

    state_t                state_reg, state_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic [SCALE_W-1:0]    scale_reg, scale_next;
    logic                  started_reg, started_next;
    logic [TIME_BITS-1:0]  last_reg, last_next;
    logic [NP_BITS-1:0]    np_reg, np_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [D_W-1:0]        d_reg, d_next;
    logic [TD_W-1:0]       td_reg, td_next;
    logic [DT_W-1:0]       dt_reg, dt_next;
    logic                  adv_reg, adv_next;
    logic                  pulse_reg, pulse_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [DIV3_W-1:0]     m3_x_reg, m3_x_next;
    logic [PROD3_W-1:0]    m3_acc_reg, m3_acc_next;

    div_req_t              dreq;
    div_rsp_t              drsp;
    rate_entry_t           lk;
    logic [DT_W-1:0]       dt_c;
    logic [DVD_W-1:0]      three_t;
    logic [DVD_W-1:0]      np0;
    logic [RATE_W-1:0]     rate_nz;
    logic [NUM_W-1:0]      num;
    logic [STEP_W-1:0]     skip_rem;
    logic [HALF3_W-1:0]    m3_part;
    logic [PROD3_W-1:0]    m3_prod;
    logic [SUM3_W-1:0]     m3_sum;
    logic [DT_W-1:0]       m3_q;

    vfpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        lk       = rate_lookup(rate_reg);
        dt_c     = DT_W'(d_reg) * DT_W'(td_reg);
        three_t  = (DVD_W'(last_reg) << 1) + DVD_W'(last_reg);
        np0      = DVD_W'(np_reg) + DVD_W'(step_reg);
        rate_nz  = (rate_reg == '0) ? RATE_ONE : rate_reg;
        num      = TICKS_X3 * NUM_W'(scale_reg);
        skip_rem = drsp.remainder[STEP_W-1:0];
        m3_part  = (state_reg == ST_STEP || state_reg == ST_ALIGN) ?
                   m3_x_reg[HALF3_W-1:0] : m3_x_reg[DIV3_W-1:HALF3_W];
        m3_prod  = PROD3_W'(m3_part) * PROD3_W'(RECIP3);
        m3_sum   = {m3_prod, {HALF3_W{1'b0}}} + SUM3_W'(m3_acc_reg);
        m3_q     = m3_sum[SUM3_W-1:RECIP3_SH];

        state_next   = state_reg;
        rate_next    = rate_reg;
        scale_next   = scale_reg;
        started_next = started_reg;
        last_next    = last_reg;
        np_next      = np_reg;
        step_next    = step_reg;
        d_next       = d_reg;
        td_next      = td_reg;
        dt_next      = dt_reg;
        adv_next     = adv_reg;
        pulse_next   = pulse_reg;
        idx_next     = idx_reg;
        m3_x_next    = m3_x_reg;
        m3_acc_next  = m3_acc_reg;
        dreq.start    = 1'b0;
        dreq.dividend = three_t;
        dreq.divisor  = dt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pulse_next = 1'b0;
                    adv_next   = now_time > last_reg;
                    if (now_time > last_reg)
                    begin
                        last_next = now_time;
                    end
                    if (started_reg)
                    begin
                        state_next = ST_DT;
                    end
                    else if (lk.hit)
                    begin
                        d_next     = lk.d;
                        td_next    = lk.td;
                        state_next = ST_DT;
                    end
                    else
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = DVD_W'(num);
                        dreq.divisor  = DVS_W'({rate_nz, 1'b0});
                        state_next    = ST_FORM;
                    end
                end
            end
            ST_FORM:
            begin
                if (drsp.done)
                begin
                    d_next     = DEFAULT_D;
                    td_next    = drsp.quotient[TD_W+1:2];
                    state_next = ST_DT;
                end
            end
            ST_DT:
            begin
                dt_next = dt_c;
                if (!started_reg)
                begin
                    if (dt_c == '0)
                    begin
                        step_next    = '0;
                        np_next      = NP_BITS'(last_reg);
                        idx_next     = '0;
                        started_next = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        m3_x_next  = DIV3_W'(dt_c) + DIV3_W'(2);
                        state_next = ST_STEP;
                    end
                end
                else if (step_reg != '0 && NP_BITS'(last_reg) >= np_reg)
                begin
                    pulse_next = 1'b1;
                    if (np0 < DVD_W'(last_reg))
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = DVD_W'(last_reg) - np0;
                        dreq.divisor  = DVS_W'(step_reg);
                        state_next    = ST_SKIP;
                    end
                    else
                    begin
                        np_next    = np0[NP_BITS-1:0];
                        state_next = ST_IDX;
                    end
                end
                else
                begin
                    state_next = ST_IDX;
                end
            end
            ST_STEP:
            begin
                m3_acc_next = m3_prod;
                state_next  = ST_STEPH;
            end
            ST_STEPH:
            begin
                step_next  = m3_q[STEP_W-1:0];
                dreq.start = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                if (drsp.done)
                begin
                    idx_next   = drsp.quotient[IDX_BITS-1:0];
                    m3_x_next  = DIV3_W'(drsp.remainder);
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                m3_acc_next = m3_prod;
                state_next  = ST_ALIGNH;
            end
            ST_ALIGNH:
            begin
                np_next = NP_BITS'(last_reg) - NP_BITS'(m3_q) + NP_BITS'(step_reg);
                started_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_SKIP:
            begin
                if (drsp.done)
                begin
                    if (skip_rem == '0)
                    begin
                        np_next = NP_BITS'(last_reg);
                    end
                    else
                    begin
                        np_next = NP_BITS'(last_reg) + NP_BITS'(step_reg - skip_rem);
                    end
                    state_next = ST_IDX;
                end
            end
            ST_IDX:
            begin
                if (dt_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = ST_IDXW;
                end
            end
            ST_IDXW:
            begin
                if (drsp.done)
                begin
                    idx_next   = drsp.quotient[IDX_BITS-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_RATE:
                begin
                    rate_next    = cfg_data;
                    started_next = 1'b0;
                end
                REG_RATE_SCALE:
                begin
                    scale_next   = cfg_data[SCALE_W-1:0];
                    started_next = 1'b0;
                end
                default:
                begin
                    started_next = started_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rate_reg    <= 16'd25;
            scale_reg   <= 10'd1;
            started_reg <= 1'b0;
            last_reg    <= '0;
            np_reg      <= '0;
            step_reg    <= '0;
            d_reg       <= DEFAULT_D;
            td_reg      <= '0;
            dt_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rate_reg    <= rate_next;
            scale_reg   <= scale_next;
            started_reg <= started_next;
            last_reg    <= last_next;
            np_reg      <= np_next;
            step_reg    <= step_next;
            d_reg       <= d_next;
            td_reg      <= td_next;
            dt_reg      <= dt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adv_reg    <= adv_next;
        pulse_reg  <= pulse_next;
        idx_reg    <= idx_next;
        m3_x_reg   <= m3_x_next;
        m3_acc_reg <= m3_acc_next;
    end

    assign in_stall        = state_reg != ST_IDLE;
    assign out_valid       = state_reg == ST_OUT;
    assign reported_time   = last_reg;
    assign time_advanced   = adv_reg;
    assign frame_pulse     = pulse_reg;
    assign next_pulse_time = np_reg;
    assign frame_index     = idx_reg;

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result delivered twice");

    a_pulse_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_pulse) |-> (next_pulse_time >= NP_BITS'(reported_time)))
        else $error("next pulse behind reported time after a pulse");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DT) |-> (last_reg >= $past(last_reg)))
        else $error("reported time went backwards");

endmodule
